// ===== sv/phl_pkg.sv =====
// Shared types and constants for the positional handle list.
// Used by the storage cell, the top level and the port checker.
package phl_pkg;

   localparam int unsigned PHL_CAPACITY     = 64;
   localparam int unsigned PHL_HANDLE_WIDTH = 16;
   localparam int unsigned PHL_PORT_HWIDTH  = 16;
   localparam int unsigned PHL_PORT_PWIDTH  = 16;
   localparam int unsigned PHL_PORT_CWIDTH  = 7;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_GET    = 2'd1,
      REQ_DELETE = 2'd2,
      REQ_CLEAR  = 2'd3
   } phl_req_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_NULL  = 2'd1,
      ST_RANGE = 2'd2,
      ST_FULL  = 2'd3
   } phl_status_type;

   // Shift command broadcast to every cell of the row.
   typedef struct packed {
      logic ins;   // open a gap at the selected cell and load the new handle
      logic del;   // close the gap at the selected cell
   } phl_shift_type;

endpackage

// ===== sv/phl_cell.sv =====
// One storage cell of the handle row: holds one handle and trades it with
// its neighbors on insert and delete. Depends on phl_pkg.
module phl_cell #(
   parameter int unsigned HANDLE_WIDTH = 16,
   parameter int unsigned IDX_W        = 6,
   parameter int unsigned INDEX        = 0
) (
   input  logic                      clock,
   input  phl_pkg::phl_shift_type    shift,
   input  logic [IDX_W-1:0]          sel_idx,
   input  logic [HANDLE_WIDTH-1:0]   handle_new,
   input  logic [HANDLE_WIDTH-1:0]   left_data,
   input  logic [HANDLE_WIDTH-1:0]   right_data,
   output logic [HANDLE_WIDTH-1:0]   data_out,
   output logic [HANDLE_WIDTH-1:0]   rd_data
);
   import phl_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [HANDLE_WIDTH-1:0] data_ff;
   logic [HANDLE_WIDTH-1:0] data_in;
   logic                    hit;
   logic                    after_sel;

   assign hit       = (sel_idx == MY_IDX);
   assign after_sel = (sel_idx < MY_IDX);

   always_comb begin
      data_in = data_ff;
      if (shift.ins) begin
         if (hit) begin
            data_in = handle_new;
         end else if (after_sel) begin
            data_in = left_data;
         end
      end else if (shift.del) begin
         if (hit || after_sel) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;
   assign rd_data  = hit ? data_ff : '0;

endmodule

// ===== sv/positional_handle_list_top.sv =====
// Positional handle list: a row of shifting cells plus an entry count.
// Depends on phl_pkg and phl_cell.
//
// Usage:
//   Requests arrive on req_* (valid/ready) with a type, a position and a
//   handle. Insert places a nonzero handle at the position (a position at or
//   past the count appends); get reads the handle at a position; delete
//   removes it and returns it; clear empties the list.
//   Each request gives exactly one result on rsp_* (valid/ready): the handle
//   read or removed (0 otherwise), a status (ok, null handle, out of range,
//   list full) and the count after the request.
//   The result is valid in the cycle after the request transfer. Every cell
//   shifts in the same cycle, so one request is taken per clock unless the receiver stalls.
//   The result sits in an output register; a new request is taken whenever
//   that register is empty or being drained in the same cycle. While the
//   receiver stalls, the result holds and req_ready stays low.
//   Reset empties the list and drops any pending result; cell contents are
//   left as they are and are never read before they are written.
module positional_handle_list_top
   import phl_pkg::*;
#(
   parameter int unsigned CAPACITY     = PHL_CAPACITY,
   parameter int unsigned HANDLE_WIDTH = PHL_HANDLE_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_type,
   input  logic [PHL_PORT_PWIDTH-1:0]    req_position,
   input  logic [PHL_PORT_HWIDTH-1:0]    req_handle_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [PHL_PORT_HWIDTH-1:0]    rsp_handle_out,
   output logic [1:0]                    rsp_status,
   output logic [PHL_PORT_CWIDTH-1:0]    rsp_count
);

   localparam int unsigned IDX_W = $clog2(CAPACITY);
   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam int unsigned CMP_W = (CNT_W > PHL_PORT_PWIDTH) ? CNT_W : PHL_PORT_PWIDTH;
   localparam int unsigned HIN_W =
      (HANDLE_WIDTH < PHL_PORT_HWIDTH) ? HANDLE_WIDTH : PHL_PORT_HWIDTH;

   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [PHL_PORT_HWIDTH-1:0] handle_ff, handle_in;
   phl_status_type             status_ff, status_in;

   logic                       accept;
   phl_req_type                req_op;
   logic                       in_range;
   logic                       full;
   logic                       is_null;
   logic [IDX_W-1:0]           sel_idx;
   logic [HANDLE_WIDTH-1:0]    handle_new;
   logic [HANDLE_WIDTH-1:0]    rd_or;
   phl_shift_type              shift;

   logic [HANDLE_WIDTH-1:0]    cell_data [CAPACITY];
   logic [HANDLE_WIDTH-1:0]    cell_rd   [CAPACITY];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign req_op    = phl_req_type'(req_type);

   assign in_range   = CMP_W'(req_position) < CMP_W'(cnt_ff);
   assign full       = (cnt_ff == CNT_W'(CAPACITY));
   assign handle_new = HANDLE_WIDTH'(req_handle_in[HIN_W-1:0]);
   assign is_null    = (handle_new == '0);
   // Insert past the end lands at the count; get and delete only use in-range positions.
   assign sel_idx    = in_range ? IDX_W'(req_position) : IDX_W'(cnt_ff);

   // Cell row
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [HANDLE_WIDTH-1:0] left_d, right_d;
      if (i == 0) begin : g_first
         assign left_d = '0;
      end else begin : g_left
         assign left_d = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_d = '0;
      end else begin : g_right
         assign right_d = cell_data[i+1];
      end
      phl_cell #(
         .HANDLE_WIDTH (HANDLE_WIDTH),
         .IDX_W        (IDX_W),
         .INDEX        (i)
      ) u_cell (
         .clock      (clock),
         .shift      (shift),
         .sel_idx    (sel_idx),
         .handle_new (handle_new),
         .left_data  (left_d),
         .right_data (right_d),
         .data_out   (cell_data[i]),
         .rd_data    (cell_rd[i])
      );
   end

   // Only the selected cell drives nonzero read data.
   always_comb begin
      rd_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_or = rd_or | cell_rd[i];
      end
   end

   // Request decode
   always_comb begin
      shift     = '0;
      cnt_in    = cnt_ff;
      handle_in = '0;
      status_in = ST_OK;
      unique case (req_op)
         REQ_INSERT: begin
            if (is_null) begin
               status_in = ST_NULL;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               shift.ins = accept;
               cnt_in    = cnt_ff + CNT_W'(1);
            end
         end
         REQ_GET: begin
            if (!in_range) begin
               status_in = ST_RANGE;
            end else begin
               handle_in = PHL_PORT_HWIDTH'(rd_or);
            end
         end
         REQ_DELETE: begin
            if (!in_range) begin
               status_in = ST_RANGE;
            end else begin
               handle_in = PHL_PORT_HWIDTH'(rd_or);
               shift.del = accept;
               cnt_in    = cnt_ff - CNT_W'(1);
            end
         end
         REQ_CLEAR: begin
            cnt_in = '0;
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            cnt_ff <= cnt_in;
         end
      end
   end

   // Hold the result payload until the next transfer.
   always_ff @(posedge clock) begin
      if (accept) begin
         handle_ff <= handle_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_handle_out = handle_ff;
   assign rsp_status     = status_ff;
   assign rsp_count      = PHL_PORT_CWIDTH'(cnt_ff);

endmodule

// ===== sv/phl_checker.sv =====
// Port-level checks for the positional handle list.
// Depends on phl_pkg; bound to positional_handle_list_top.
module phl_checker
   import phl_pkg::*;
#(
   parameter int unsigned CAPACITY = PHL_CAPACITY
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic [1:0]                 req_type,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [PHL_PORT_HWIDTH-1:0] rsp_handle_out,
   input logic [1:0]                 rsp_status,
   input logic [PHL_PORT_CWIDTH-1:0] rsp_count
);

   // No result may linger across reset.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A clear transfer shows an empty list in the cycle after it.
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_type == REQ_CLEAR) |=>
         (rsp_valid && rsp_count == '0 && rsp_handle_out == '0 && rsp_status == ST_OK))
      else $error("clear did not empty the list");

   // A refused request returns no handle.
   a_fail_no_handle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> rsp_handle_out == '0)
      else $error("failed request returned a handle");

   // Count stays within capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CAPACITY > 127 || 32'(rsp_count) <= CAPACITY))
      else $error("count beyond capacity");

   // Take no new request while a stalled result waits.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request taken while result stalled");

endmodule

bind positional_handle_list_top phl_checker #(
   .CAPACITY (CAPACITY)
) u_phl_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_type       (req_type),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_handle_out (rsp_handle_out),
   .rsp_status     (rsp_status),
   .rsp_count      (rsp_count)
);

// ===== sim/tb_positional_handle_list_top.sv =====
// Self-checking testbench for positional_handle_list_top: a directed table, then random
// insert/get/delete/clear traffic with random stalls, each response checked in order.
// Depends on phl_pkg and the positional_handle_list_top RTL.
`timescale 1ns / 1ps

module tb_positional_handle_list_top;
   import phl_pkg::*;

   localparam int unsigned DEPTH          = PHL_CAPACITY;
   localparam int          RANDOM_ITEMS   = 1400;
   localparam int          WATCHDOG_LIMIT = 5000;
   localparam int          MAX_REPORTS    = 40;

   typedef struct packed {
      logic [PHL_PORT_HWIDTH-1:0] handle;
      phl_status_type             status;
      logic [PHL_PORT_CWIDTH-1:0] count;
   } list_result_type;

   typedef struct {
      phl_req_type                op;
      logic [PHL_PORT_PWIDTH-1:0] pos;
      logic [PHL_PORT_HWIDTH-1:0] handle;
      bit                         typed;
      list_result_type            exp;
   } stim_row_type;

   logic                       clock         = 1'b0;
   logic                       reset         = 1'b1;
   logic                       req_valid     = 1'b0;
   logic [1:0]                 req_type      = REQ_INSERT;
   logic [PHL_PORT_PWIDTH-1:0] req_position  = '0;
   logic [PHL_PORT_HWIDTH-1:0] req_handle_in = '0;
   logic                       rsp_ready     = 1'b0;
   logic                       req_ready;
   logic                       rsp_valid;
   logic [PHL_PORT_HWIDTH-1:0] rsp_handle_out;
   logic [1:0]                 rsp_status;
   logic [PHL_PORT_CWIDTH-1:0] rsp_count;

   // Hand-written expectation that travels with the request currently on the bus.
   bit              row_typed = 1'b0;
   list_result_type row_exp   = '0;

   // Shadow copy of the list.
   logic [PHL_HANDLE_WIDTH-1:0] slot_handles [DEPTH];
   int unsigned                 list_len = 0;

   list_result_type expected_q [$];
   stim_row_type    directed_rows [$];

   int  err_count   = 0;
   int  n_results   = 0;
   int  n_op [4]    = '{default: 0};
   int  n_stat [4]  = '{default: 0};
   int  deepest     = 0;
   int  idle_cycles = 0;
   int  stall_left  = 0;
   bit  quiet       = 1'b0;

   positional_handle_list_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_position   (req_position),
      .req_handle_in  (req_handle_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_handle_out (rsp_handle_out),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 0;
   end

   // Apply one request to the shadow list and return the response it must produce.
   function automatic list_result_type apply_request(phl_req_type op,
                                                     logic [PHL_PORT_PWIDTH-1:0] pos,
                                                     logic [PHL_PORT_HWIDTH-1:0] h);
      list_result_type             r;
      logic [PHL_HANDLE_WIDTH-1:0] hk;
      int unsigned                 p;
      int unsigned                 i;
      r.handle = '0;
      r.status = ST_OK;
      hk = h[PHL_HANDLE_WIDTH-1:0];
      p = pos;
      case (op)
         REQ_INSERT: begin
            if (hk == '0) begin
               r.status = ST_NULL;
            end else if (list_len >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               // positions past the tail append
               if (p > list_len) p = list_len;
               for (i = list_len; i > p; i--) slot_handles[i] = slot_handles[i-1];
               slot_handles[p] = hk;
               list_len++;
            end
         end
         REQ_GET: begin
            if (p >= list_len) r.status = ST_RANGE;
            else r.handle = slot_handles[p];
         end
         REQ_DELETE: begin
            if (p >= list_len) begin
               r.status = ST_RANGE;
            end else begin
               r.handle = slot_handles[p];
               for (i = p; i + 1 < list_len; i++) slot_handles[i] = slot_handles[i+1];
               list_len--;
            end
         end
         default: list_len = 0;
      endcase
      r.count = 7'(list_len);
      return r;
   endfunction

   task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
      err_count++;
      if (err_count <= MAX_REPORTS)
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
   endtask

   // Response checker, predictor hook and watchdog.
   always @(posedge clock) begin
      list_result_type want;
      list_result_type pred;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            n_results++;
            if (expected_q.size() == 0) begin
               err_count++;
               if (err_count <= MAX_REPORTS)
                  $display("%0t: unexpected response: expected none, actual %h/%0d/%0d",
                           $time, rsp_handle_out, rsp_status, rsp_count);
            end else begin
               want = expected_q.pop_front();
               if (rsp_handle_out !== want.handle)
                  note_mismatch("handle_out", want.handle, rsp_handle_out);
               if (rsp_status !== want.status)
                  note_mismatch("status", want.status, rsp_status);
               if (rsp_count !== want.count)
                  note_mismatch("count", want.count, rsp_count);
            end
         end
         if (req_valid && req_ready) begin
            pred = apply_request(phl_req_type'(req_type), req_position, req_handle_in);
            expected_q.push_back(row_typed ? row_exp : pred);
            n_op[req_type]++;
            n_stat[pred.status]++;
            if (list_len > deepest) deepest = list_len;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog: no transfer for %0d cycles, %0d responses pending",
                     $time, idle_cycles, expected_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Receiver: random stall bursts unless in a quiet stretch.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 4);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic add_row(phl_req_type op, logic [15:0] pos, logic [15:0] h, bit typed,
                          logic [15:0] eh, phl_status_type es, logic [6:0] ec);
      stim_row_type row;
      row.op = op;
      row.pos = pos;
      row.handle = h;
      row.typed = typed;
      row.exp.handle = eh;
      row.exp.status = es;
      row.exp.count = ec;
      directed_rows.push_back(row);
   endtask

   // Present one request, after an optional gap, and hold it until the transfer.
   task automatic send_request(stim_row_type row, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= row.op;
      req_position  <= row.pos;
      req_handle_in <= row.handle;
      row_typed     <= row.typed;
      row_exp       <= row.exp;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   initial begin
      stim_row_type row;
      int           mode;
      int           r;
      int           gap;
      int unsigned  cur;

      add_row(REQ_GET,    0,        0,        1, 0,        ST_RANGE, 0);
      add_row(REQ_DELETE, 16'hFFFF, 16'h1234, 1, 0,        ST_RANGE, 0);
      add_row(REQ_INSERT, 0,        0,        1, 0,        ST_NULL,  0);
      add_row(REQ_CLEAR,  16'hFFFF, 16'hFFFF, 1, 0,        ST_OK,    0);
      add_row(REQ_INSERT, 0,        16'hFFFF, 1, 0,        ST_OK,    1);
      add_row(REQ_INSERT, 16'hFFFF, 16'h0001, 1, 0,        ST_OK,    2);
      add_row(REQ_GET,    0,        0,        1, 16'hFFFF, ST_OK,    2);
      add_row(REQ_GET,    1,        0,        1, 16'h0001, ST_OK,    2);
      add_row(REQ_GET,    2,        0,        1, 0,        ST_RANGE, 2);
      add_row(REQ_INSERT, 1,        16'h8000, 1, 0,        ST_OK,    3);
      add_row(REQ_GET,    1,        16'hFFFF, 1, 16'h8000, ST_OK,    3);
      add_row(REQ_DELETE, 0,        0,        1, 16'hFFFF, ST_OK,    2);
      add_row(REQ_GET,    0,        0,        1, 16'h8000, ST_OK,    2);
      add_row(REQ_DELETE, 2,        0,        1, 0,        ST_RANGE, 2);
      add_row(REQ_DELETE, 1,        0,        1, 16'h0001, ST_OK,    1);
      add_row(REQ_CLEAR,  0,        0,        1, 0,        ST_OK,    0);
      add_row(REQ_GET,    0,        0,        1, 0,        ST_RANGE, 0);
      // fill to capacity at scattered positions
      for (int i = 0; i < DEPTH; i++)
         add_row(REQ_INSERT, (i == 5) ? 16'hFFFF : 16'($urandom_range(0, i)),
                 16'($urandom_range(1, 16'hFFFF)), 1, 0, ST_OK, 7'(i + 1));
      add_row(REQ_INSERT, 3,        16'h1234, 1, 0,        ST_FULL,  64);
      // null check wins over full check
      add_row(REQ_INSERT, 0,        0,        1, 0,        ST_NULL,  64);
      add_row(REQ_GET,    63,       0,        0, 0,        ST_OK,    0);
      add_row(REQ_GET,    64,       0,        1, 0,        ST_RANGE, 64);
      add_row(REQ_DELETE, 0,        0,        0, 0,        ST_OK,    0);
      add_row(REQ_INSERT, 16'hFFFF, 16'h5A5A, 1, 0,        ST_OK,    64);
      add_row(REQ_GET,    63,       0,        1, 16'h5A5A, ST_OK,    64);
      add_row(REQ_DELETE, 63,       0,        1, 16'h5A5A, ST_OK,    63);
      add_row(REQ_CLEAR,  7,        16'h7777, 1, 0,        ST_OK,    0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i], ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0);

      mode = 2;
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         quiet = (k >= 300 && k < 400) || (k >= RANDOM_ITEMS - 200);
         if (k % 150 == 0) mode = $urandom_range(0, 2);
         if (k == RANDOM_ITEMS / 2) begin
            // drain: hold off until every outstanding response is back
            req_valid <= 1'b0;
            @(posedge clock);
            while (expected_q.size() != 0) @(posedge clock);
         end
         // list length only biases the choice, so a one-item lag is harmless
         cur = list_len;
         r = $urandom_range(0, 999);
         case (mode)
            0:       row.op = (r < 700) ? REQ_INSERT : (r < 850) ? REQ_GET :
                              (r < 998) ? REQ_DELETE : REQ_CLEAR;
            1:       row.op = (r < 250) ? REQ_INSERT : (r < 450) ? REQ_GET :
                              (r < 985) ? REQ_DELETE : REQ_CLEAR;
            default: row.op = (r < 400) ? REQ_INSERT : (r < 700) ? REQ_GET :
                              (r < 975) ? REQ_DELETE : REQ_CLEAR;
         endcase
         r = $urandom_range(0, 9);
         if (r < 7)       row.pos = 16'($urandom_range(0, cur));
         else if (r == 7) row.pos = 16'(cur);
         else if (r == 8) row.pos = 16'($urandom);
         else             row.pos = 16'hFFFF;
         row.handle = ($urandom_range(0, 19) == 0) ? 16'h0000
                                                   : 16'($urandom_range(1, 16'hFFFF));
         row.typed = 1'b0;
         row.exp = '0;
         gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
         send_request(row, gap);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (expected_q.size() != 0) begin
         err_count++;
         $display("%0t: %0d responses never arrived", $time, expected_q.size());
      end

      $display("Ran %0d requests (insert %0d, get %0d, delete %0d, clear %0d), %0d responses",
               n_op[REQ_INSERT] + n_op[REQ_GET] + n_op[REQ_DELETE] + n_op[REQ_CLEAR],
               n_op[REQ_INSERT], n_op[REQ_GET], n_op[REQ_DELETE], n_op[REQ_CLEAR], n_results);
      $display("Null refusals %0d, out of range %0d, full refusals %0d, deepest list %0d",
               n_stat[ST_NULL], n_stat[ST_RANGE], n_stat[ST_FULL], deepest);
      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
